/* hw/rtl/kvt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value text tokenizer.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = 2;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  localparam logic [7:0] ChOpen   = 8'h7B;
  localparam logic [7:0] ChClose  = 8'h7D;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChCr     = 8'h0D;

  localparam logic FuncByte = 1'b0;
  localparam logic FuncEot  = 1'b1;

  typedef enum logic [2:0] {
    KindByte  = 3'd0,
    KindSend  = 3'd1,
    KindOpen  = 3'd2,
    KindClose = 3'd3,
    KindEot   = 3'd4
  } token_kind_e;

  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeSlash   = 3'd1,
    ModeComment = 3'd2,
    ModeBare    = 3'd3,
    ModeQuoted  = 3'd4,
    ModeEscape  = 3'd5
  } lex_mode_e;

  typedef struct packed {
    logic [CntW-1:0]          cnt;
    token_kind_e [MaxRes-1:0] kind;
    logic [MaxRes-1:0][7:0]   data;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hw/rtl/kvt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_in_if / kvt_out_if
// Valid/ready channels for text items and token items.
// ----------------------------------------------------------------------------
interface kvt_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] text_byte;
  modport source (output valid, output func, output text_byte, input ready);
  modport sink (input valid, input func, input text_byte, output ready);
endinterface

interface kvt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] out_byte;
  logic       run_last;
  modport source (output valid, output token_kind, output out_byte, output run_last,
                  input ready);
  modport sink (input valid, input token_kind, input out_byte, input run_last,
                output ready);
endinterface

/* hw/rtl/kvt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_front
// Accepts text items, keeps the lexing mode and forms the result bundle.
// ----------------------------------------------------------------------------
module kvt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [7:0]           text_byte_i,
  input  kvt_pkg::q_status_t   q_status_i,
  output logic                 push_o,
  output kvt_pkg::bundle_t     bundle_o
);

  kvt_pkg::lex_mode_e mode_q, mode_d;
  kvt_pkg::bundle_t   b;
  logic               accept;

  function automatic kvt_pkg::bundle_t add_res(kvt_pkg::bundle_t bi,
                                               kvt_pkg::token_kind_e k,
                                               logic [7:0] by);
    kvt_pkg::bundle_t bo;
    bo = bi;
    bo.kind[bi.cnt] = k;
    bo.data[bi.cnt] = (k == kvt_pkg::KindByte) ? by : 8'h00;
    bo.cnt = bi.cnt + 1'b1;
    return bo;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == kvt_pkg::ChSpace) || ((c >= kvt_pkg::ChTab) && (c <= kvt_pkg::ChCr));
  endfunction

  function automatic kvt_pkg::bundle_t bare_res(kvt_pkg::bundle_t bi, logic [7:0] c);
    kvt_pkg::bundle_t bo;
    bo = bi;
    if (is_ws(c)) begin
      bo = add_res(bo, kvt_pkg::KindSend, 8'h00);
    end else if (c == kvt_pkg::ChOpen) begin
      bo = add_res(bo, kvt_pkg::KindSend, 8'h00);
      bo = add_res(bo, kvt_pkg::KindOpen, 8'h00);
    end else if (c == kvt_pkg::ChClose) begin
      bo = add_res(bo, kvt_pkg::KindSend, 8'h00);
      bo = add_res(bo, kvt_pkg::KindClose, 8'h00);
    end else begin
      bo = add_res(bo, kvt_pkg::KindByte, c);
    end
    return bo;
  endfunction

  function automatic kvt_pkg::lex_mode_e bare_mode(logic [7:0] c);
    if (is_ws(c) || (c == kvt_pkg::ChOpen) || (c == kvt_pkg::ChClose)) begin
      return kvt_pkg::ModeIdle;
    end
    return kvt_pkg::ModeBare;
  endfunction

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    b      = '0;
    mode_d = mode_q;
    if (func_i == kvt_pkg::FuncEot) begin
      unique case (mode_q)
        kvt_pkg::ModeSlash: begin
          b = add_res(b, kvt_pkg::KindByte, kvt_pkg::ChSlash);
          b = add_res(b, kvt_pkg::KindSend, 8'h00);
        end
        kvt_pkg::ModeBare, kvt_pkg::ModeQuoted: begin
          b = add_res(b, kvt_pkg::KindSend, 8'h00);
        end
        kvt_pkg::ModeEscape: begin
          b = add_res(b, kvt_pkg::KindByte, kvt_pkg::ChBslash);
          b = add_res(b, kvt_pkg::KindSend, 8'h00);
        end
        default: begin
        end
      endcase
      b      = add_res(b, kvt_pkg::KindEot, 8'h00);
      mode_d = kvt_pkg::ModeIdle;
    end else begin
      unique case (mode_q)
        kvt_pkg::ModeSlash: begin
          if (text_byte_i == kvt_pkg::ChSlash) begin
            mode_d = kvt_pkg::ModeComment;
          end else begin
            b      = add_res(b, kvt_pkg::KindByte, kvt_pkg::ChSlash);
            b      = bare_res(b, text_byte_i);
            mode_d = bare_mode(text_byte_i);
          end
        end
        kvt_pkg::ModeComment: begin
          if (text_byte_i == kvt_pkg::ChNl) begin
            mode_d = kvt_pkg::ModeIdle;
          end
        end
        kvt_pkg::ModeBare: begin
          b      = bare_res(b, text_byte_i);
          mode_d = bare_mode(text_byte_i);
        end
        kvt_pkg::ModeQuoted: begin
          if (text_byte_i == kvt_pkg::ChQuote) begin
            b      = add_res(b, kvt_pkg::KindSend, 8'h00);
            mode_d = kvt_pkg::ModeIdle;
          end else if (text_byte_i == kvt_pkg::ChBslash) begin
            mode_d = kvt_pkg::ModeEscape;
          end else begin
            b = add_res(b, kvt_pkg::KindByte, text_byte_i);
          end
        end
        kvt_pkg::ModeEscape: begin
          if (text_byte_i == kvt_pkg::ChLowN) begin
            b = add_res(b, kvt_pkg::KindByte, kvt_pkg::ChNl);
          end else if (text_byte_i == kvt_pkg::ChLowT) begin
            b = add_res(b, kvt_pkg::KindByte, kvt_pkg::ChTab);
          end else begin
            b = add_res(b, kvt_pkg::KindByte, text_byte_i);
          end
          mode_d = kvt_pkg::ModeQuoted;
        end
        default: begin
          mode_d = kvt_pkg::ModeIdle;
          if (is_ws(text_byte_i)) begin
          end else if (text_byte_i == kvt_pkg::ChOpen) begin
            b = add_res(b, kvt_pkg::KindOpen, 8'h00);
          end else if (text_byte_i == kvt_pkg::ChClose) begin
            b = add_res(b, kvt_pkg::KindClose, 8'h00);
          end else if (text_byte_i == kvt_pkg::ChQuote) begin
            mode_d = kvt_pkg::ModeQuoted;
          end else if (text_byte_i == kvt_pkg::ChSlash) begin
            mode_d = kvt_pkg::ModeSlash;
          end else begin
            b      = add_res(b, kvt_pkg::KindByte, text_byte_i);
            mode_d = kvt_pkg::ModeBare;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kvt_pkg::ModeIdle;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  assign push_o   = accept && (b.cnt != '0);
  assign bundle_o = b;

endmodule

/* hw/rtl/kvt_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module kvt_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  kvt_pkg::bundle_t   push_data_i,
  input  logic               pop_i,
  output kvt_pkg::bundle_t   head_o,
  output kvt_pkg::q_status_t status_o
);

  kvt_pkg::bundle_t [kvt_pkg::QDepth-1:0] mem_q;
  logic [kvt_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [kvt_pkg::QCntW-1:0] cnt_q;
  logic                      do_push, do_pop;

  function automatic logic [kvt_pkg::QCntW-1:0] QCntWExt(logic v);
    return {{(kvt_pkg::QCntW-1){1'b0}}, v};
  endfunction

  assign status_o.full  = (cnt_q == kvt_pkg::QCntW'(kvt_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntWExt(do_push) - QCntWExt(do_pop);
    end
  end

endmodule

/* hw/rtl/kvt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_back
// Splits each bundle into result items and holds them in an output register.
// ----------------------------------------------------------------------------
module kvt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvt_pkg::bundle_t   head_i,
  input  kvt_pkg::q_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         token_kind_o,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o
);

  logic [kvt_pkg::CntW-1:0] idx_q, idx_d;
  logic                     valid_q, valid_d;
  logic [2:0]               kind_q;
  logic [7:0]               byte_q;
  logic                     last_q, last_d;
  logic                     load;

  assign load   = (!valid_q || out_ready_i) && !q_status_i.empty;
  assign last_d = (idx_q == head_i.cnt - 1'b1);
  assign pop_o  = load && last_d;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q && !out_ready_i;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = last_d ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind[idx_q];
      byte_q <= head_i.data[idx_q];
      last_q <= last_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign token_kind_o = kind_q;
  assign out_byte_o   = byte_q;
  assign run_last_o   = last_q;

endmodule

/* hw/rtl/keyvalue_text_tokenizer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer_unit
// Byte-serial lexer for brace-structured key/value text.
// An accepted item's results pass through the bundle queue into the output
// register. Throughput: one text item per cycle while the queue is not full;
// the output register drains one result item per cycle while out_o.ready is
// high. A two-entry bundle queue sets how far input may run ahead of output.
// Reset clears the lexing mode to idle and empties queue and output.
// ----------------------------------------------------------------------------
module keyvalue_text_tokenizer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  kvt_in_if.sink     in_i,
  kvt_out_if.source  out_o
);

  logic               push, pop;
  kvt_pkg::bundle_t   push_data, head;
  kvt_pkg::q_status_t q_status;

  kvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .func_i      (in_i.func),
    .text_byte_i (in_i.text_byte),
    .q_status_i  (q_status),
    .push_o      (push),
    .bundle_o    (push_data)
  );

  kvt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  kvt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .token_kind_o (out_o.token_kind),
    .out_byte_o   (out_o.out_byte),
    .run_last_o   (out_o.run_last)
  );

  a_q_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.token_kind == kvt_pkg::KindEot)) |-> out_o.run_last)
    else $error("end-of-text item is not the last of its run");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.token_kind != kvt_pkg::KindByte)) |-> (out_o.out_byte == 8'h00))
    else $error("non-byte token carries a nonzero byte");

endmodule

/* tb/sv/kvt_token_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_token_check
// Watches the text and token channels of the key/value text tokenizer. It
// keeps its own lexing mode, works out the token items each accepted text
// item should cause, and compares every accepted token item with the oldest
// one still due. It hands the mismatch count and the number of token items
// still due to the testbench top.
// ----------------------------------------------------------------------------
module kvt_token_check
  import kvt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  kvt_in_if    text_i,
  kvt_out_if   token_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  data;
    logic        last;
  } token_t;

  token_t    due_tokens[$];
  lex_mode_e lex_mode_q;
  int        mismatches;

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void push_token(token_kind_e kind, logic [7:0] data);
    token_t tok;
    tok.kind = kind;
    tok.data = (kind == KindByte) ? data : 8'h00;
    tok.last = 1'b0;
    due_tokens.insert(due_tokens.size(), tok);
  endfunction

  function automatic void lex_bare_byte(logic [7:0] c);
    if (is_blank(c)) begin
      push_token(KindSend, 8'h00);
      lex_mode_q = ModeIdle;
    end else if (c == ChOpen || c == ChClose) begin
      push_token(KindSend, 8'h00);
      push_token((c == ChOpen) ? KindOpen : KindClose, 8'h00);
      lex_mode_q = ModeIdle;
    end else begin
      push_token(KindByte, c);
      lex_mode_q = ModeBare;
    end
  endfunction

  function automatic void lex_text_item(logic func, logic [7:0] c);
    int start_size;
    start_size = due_tokens.size();
    if (func == FuncEot) begin
      case (lex_mode_q)
        ModeSlash: begin
          push_token(KindByte, ChSlash);
          push_token(KindSend, 8'h00);
        end
        ModeBare, ModeQuoted: begin
          push_token(KindSend, 8'h00);
        end
        ModeEscape: begin
          push_token(KindByte, ChBslash);
          push_token(KindSend, 8'h00);
        end
        default: begin
        end
      endcase
      push_token(KindEot, 8'h00);
      lex_mode_q = ModeIdle;
    end else begin
      case (lex_mode_q)
        ModeSlash: begin
          if (c == ChSlash) begin
            lex_mode_q = ModeComment;
          end else begin
            push_token(KindByte, ChSlash);
            lex_bare_byte(c);
          end
        end
        ModeComment: begin
          if (c == ChNl) lex_mode_q = ModeIdle;
        end
        ModeBare: begin
          lex_bare_byte(c);
        end
        ModeQuoted: begin
          if (c == ChQuote) begin
            push_token(KindSend, 8'h00);
            lex_mode_q = ModeIdle;
          end else if (c == ChBslash) begin
            lex_mode_q = ModeEscape;
          end else begin
            push_token(KindByte, c);
          end
        end
        ModeEscape: begin
          if (c == ChLowN) push_token(KindByte, ChNl);
          else if (c == ChLowT) push_token(KindByte, ChTab);
          else push_token(KindByte, c);
          lex_mode_q = ModeQuoted;
        end
        default: begin
          lex_mode_q = ModeIdle;
          if (is_blank(c)) begin
          end else if (c == ChOpen) begin
            push_token(KindOpen, 8'h00);
          end else if (c == ChClose) begin
            push_token(KindClose, 8'h00);
          end else if (c == ChQuote) begin
            lex_mode_q = ModeQuoted;
          end else if (c == ChSlash) begin
            lex_mode_q = ModeSlash;
          end else begin
            push_token(KindByte, c);
            lex_mode_q = ModeBare;
          end
        end
      endcase
    end
    if (due_tokens.size() > start_size) due_tokens[due_tokens.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      lex_mode_q = ModeIdle;
      due_tokens.delete();
      mismatches = 0;
    end else begin
      if (text_i.valid && text_i.ready) lex_text_item(text_i.func, text_i.text_byte);
      if (token_i.valid && token_i.ready) begin
        if (due_tokens.size() == 0) begin
          $display("%0t: unexpected token item kind=%0d byte=%02h last=%0b", $time,
                   token_i.token_kind, token_i.out_byte, token_i.run_last);
          mismatches++;
        end else begin
          want = due_tokens.pop_front();
          if (token_i.token_kind !== want.kind || token_i.out_byte !== want.data ||
              token_i.run_last !== want.last) begin
            $display("%0t: token mismatch: expected kind=%0d byte=%02h last=%0b, %s%0d %s%02h %s%0b",
                     $time, want.kind, want.data, want.last, "actual kind=",
                     token_i.token_kind, "byte=", token_i.out_byte, "last=",
                     token_i.run_last);
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= due_tokens.size();
  end

endmodule

/* tb/sv/keyvalue_text_tokenizer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer_unit_test
// Drives text items into the key/value text tokenizer: a directed run over
// braces, quoted strings with escapes, comments, lone slashes and end of text,
// then mostly well-formed random text with some noise. Both channels idle at
// random, the token side holds off once for a long stretch, and the text side
// pauses once until all token items are out. Checking is done by
// kvt_token_check.
// ----------------------------------------------------------------------------
module keyvalue_text_tokenizer_unit_test;
  import kvt_pkg::*;

  localparam int ItemTarget = 430;
  localparam int HoldCycles = 80;
  localparam int CycleLimit = 100000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   items_sent = 0;
  int   cycle_count = 0;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;

  kvt_in_if  in_if ();
  kvt_out_if out_if ();

  keyvalue_text_tokenizer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  kvt_token_check u_token_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (in_if),
    .token_i      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 10);
      end
    end
  end

  task automatic send_item(input logic func, input logic [7:0] c);
    while (idle_on && $urandom_range(99) < 10) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= func;
    in_if.text_byte <= c;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic drain_tokens();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] blank_byte();
    if ($urandom_range(3) == 0) return ChSpace;
    return ChTab + 8'($urandom_range(4));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == ChSpace || (c >= ChTab && c <= ChCr) || c == ChOpen ||
               c == ChClose || c == ChQuote || c == ChBslash);
    return c;
  endfunction

  task automatic send_fragment();
    int         pick;
    int         len;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_item(FuncByte, blank_byte());
    end else if (pick < 22) begin
      send_item(FuncByte, ($urandom_range(1) != 0) ? ChOpen : ChClose);
    end else if (pick < 45) begin
      send_item(FuncByte, ChQuote);
      len = $urandom_range(6);
      repeat (len) begin
        if ($urandom_range(4) == 0) begin
          send_item(FuncByte, ChBslash);
          case ($urandom_range(4))
            0: c = ChLowN;
            1: c = ChLowT;
            2: c = ChQuote;
            3: c = ChBslash;
            default: c = 8'($urandom_range(255));
          endcase
          send_item(FuncByte, c);
        end else begin
          send_item(FuncByte, ($urandom_range(7) == 0) ? blank_byte() : plain_byte());
        end
      end
      if ($urandom_range(9) != 0) send_item(FuncByte, ChQuote);
    end else if (pick < 70) begin
      send_item(FuncByte, ($urandom_range(5) == 0) ? ChSlash : plain_byte());
      len = $urandom_range(5);
      repeat (len) send_item(FuncByte, ($urandom_range(7) == 0) ? ChSlash : plain_byte());
      case ($urandom_range(3))
        0: send_item(FuncByte, ChOpen);
        1: send_item(FuncByte, ChClose);
        default: send_item(FuncByte, blank_byte());
      endcase
    end else if (pick < 80) begin
      send_item(FuncByte, ChSlash);
      send_item(FuncByte, ChSlash);
      len = $urandom_range(6);
      repeat (len) begin
        c = 8'($urandom_range(255));
        send_item(FuncByte, (c == ChNl) ? ChQuote : c);
      end
      send_item(FuncByte, ChNl);
    end else if (pick < 86) begin
      send_item(FuncEot, 8'($urandom_range(255)));
    end else begin
      send_item(($urandom_range(15) == 0) ? FuncEot : FuncByte, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    in_if.valid     <= 1'b0;
    in_if.func      <= FuncByte;
    in_if.text_byte <= 8'h00;
    out_if.ready    <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(FuncByte, ChOpen);
    send_item(FuncByte, 8'h00);
    send_item(FuncByte, 8'hFF);
    send_item(FuncByte, ChClose);
    send_item(FuncByte, ChQuote);
    send_item(FuncByte, ChBslash);
    send_item(FuncByte, ChLowN);
    send_item(FuncByte, ChBslash);
    send_item(FuncByte, ChLowT);
    send_item(FuncByte, ChBslash);
    send_item(FuncByte, ChQuote);
    send_item(FuncByte, ChQuote);
    send_item(FuncByte, ChSlash);
    send_item(FuncByte, 8'h6B);
    send_item(FuncByte, ChQuote);
    send_item(FuncByte, ChSpace);
    send_item(FuncByte, ChSlash);
    send_item(FuncByte, ChSlash);
    send_item(FuncByte, 8'h0B);
    send_item(FuncByte, ChNl);
    send_item(FuncByte, ChSlash);
    send_item(FuncEot, 8'hFF);
    send_item(FuncByte, ChQuote);
    send_item(FuncByte, ChBslash);
    send_item(FuncEot, 8'h00);

    while (items_sent < 160) send_fragment();
    hold_req = 1'b1;
    while (items_sent < 200) send_fragment();
    drain_tokens();
    idle_on = 1'b0;
    while (items_sent < 300) send_fragment();
    idle_on = 1'b1;
    while (items_sent < ItemTarget) send_fragment();
    drain_tokens();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_if.sv
hw/rtl/kvt_front.sv
hw/rtl/kvt_queue.sv
hw/rtl/kvt_back.sv
hw/rtl/keyvalue_text_tokenizer_unit.sv
tb/sv/kvt_token_check.sv
tb/sv/keyvalue_text_tokenizer_unit_test.sv
